// File: hw/rtl/deq_pkg.sv
// ----------------------------------------------------------------------------
// Deque package
// Sizes, request and status codes, controller states, the command and status
// groups between controller and datapath, and ring index helpers.
// ----------------------------------------------------------------------------
package deq_pkg;

	localparam int DEPTH    = 64;
	localparam int IDX_W    = $clog2(DEPTH);
	localparam int CNT_W    = $clog2(DEPTH + 1);
	localparam int SUM_W    = IDX_W + 1;
	localparam int VALUE_W  = 32;
	localparam int REQ_W    = 3;
	localparam int STATUS_W = 2;

	localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
	localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
	localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
	localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
	localparam logic [REQ_W-1:0] REQ_PEEK_FRONT = 3'd4;
	localparam logic [REQ_W-1:0] REQ_PEEK_BACK  = 3'd5;
	localparam logic [REQ_W-1:0] REQ_DUMP_FWD   = 3'd6;
	localparam logic [REQ_W-1:0] REQ_DUMP_REV   = 3'd7;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [SUM_W-1:0] sum_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_READ
	} deq_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic latch;     // capture the accepted request
		logic exec;      // carry out a push, pop or refusal and load its result
		logic rd_first;  // start a peek or dump with the first store read
		logic rd_next;   // step to the next entry of a dump
		logic load_rd;   // load the result register from the store read data
	} deq_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic needs_read;  // the held request reads the store
		logic last_elem;   // the read data is the final result of the request
		logic slot_free;   // the result register can take a new result
	} deq_stat_t;

	// Folds a sum below twice the depth back onto the ring.
	function automatic idx_t ring_wrap(sum_t s);
		sum_t t;
		t = (s >= sum_t'(DEPTH)) ? s - sum_t'(DEPTH) : s;
		return t[IDX_W-1:0];
	endfunction

	function automatic idx_t ring_inc(idx_t i);
		return (i == idx_t'(DEPTH - 1)) ? '0 : i + idx_t'(1);
	endfunction

	function automatic idx_t ring_dec(idx_t i);
		return (i == '0) ? idx_t'(DEPTH - 1) : i - idx_t'(1);
	endfunction

endpackage

// File: hw/rtl/deq_ifs.sv
// ----------------------------------------------------------------------------
// Deque channel interfaces
// Valid/ready channels for requests and for results.
// ----------------------------------------------------------------------------
interface deq_req_if;
	import deq_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [REQ_W-1:0]          req_type;
	logic signed [VALUE_W-1:0] item_value;

	modport source (output valid, output req_type, output item_value, input ready);
	modport sink   (input valid, input req_type, input item_value, output ready);
endinterface

interface deq_rsp_if;
	import deq_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] out_value;
	logic [STATUS_W-1:0]       status;
	logic                      last_of_run;

	modport source (output valid, output out_value, output status, output last_of_run,
		input ready);
	modport sink   (input valid, input out_value, input status, input last_of_run,
		output ready);
endinterface

// File: hw/rtl/deq_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module deq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// File: hw/rtl/deq_ctrl.sv
// ----------------------------------------------------------------------------
// Deque controller
// Sequences accept, execute and store read phases of each request.
// ----------------------------------------------------------------------------
module deq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  deq_pkg::deq_stat_t stat,
	output deq_pkg::deq_cmd_t  cmd
);
	import deq_pkg::*;

	deq_state_t state_q;
	deq_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_nxt = S_EXEC;
				end
			end
			S_EXEC: begin
				if (stat.needs_read) begin
					state_nxt = S_READ;
				end else if (stat.slot_free) begin
					state_nxt = S_IDLE;
				end
			end
			S_READ: begin
				if (stat.slot_free && stat.last_elem) begin
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				cmd.latch = req_valid;
			end
			S_EXEC: begin
				if (stat.needs_read) begin
					cmd.rd_first = 1'b1;
				end else begin
					cmd.exec = stat.slot_free;
				end
			end
			S_READ: begin
				if (stat.slot_free) begin
					cmd.load_rd = 1'b1;
					cmd.rd_next = !stat.last_elem;
				end
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end
endmodule

// File: hw/rtl/deq_dp.sv
// ----------------------------------------------------------------------------
// Deque datapath
// Ring pointers, value store, dump stepping and the result register.
// ----------------------------------------------------------------------------
module deq_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [deq_pkg::REQ_W-1:0]         req_type,
	input  logic signed [deq_pkg::VALUE_W-1:0] item_value,
	input  deq_pkg::deq_cmd_t                 cmd,
	output deq_pkg::deq_stat_t                stat,
	deq_rsp_if.source                         rsp
);
	import deq_pkg::*;

	logic [REQ_W-1:0]          kind_q;
	logic signed [VALUE_W-1:0] value_q;
	idx_t                      front_q;
	cnt_t                      count_q;
	cnt_t                      dump_i_q;
	idx_t                      addr_q;
	logic                      out_valid_q;
	logic signed [VALUE_W-1:0] out_value_q;
	logic [STATUS_W-1:0]       status_q;
	logic                      last_q;

	logic                      empty;
	logic                      full;
	logic                      from_back;
	logic                      is_peek;
	logic                      is_rd_kind;
	idx_t                      back_slot;
	idx_t                      tail_idx;
	idx_t                      front_nxt;
	cnt_t                      count_nxt;
	logic [STATUS_W-1:0]       exec_status;
	logic                      wr_ok;
	idx_t                      waddr;
	logic                      ram_re;
	idx_t                      raddr;
	logic [VALUE_W-1:0]        rd_data;

	assign empty      = (count_q == '0);
	assign full       = (count_q == cnt_t'(DEPTH));
	assign from_back  = (kind_q == REQ_PEEK_BACK) || (kind_q == REQ_DUMP_REV);
	assign is_peek    = (kind_q == REQ_PEEK_FRONT) || (kind_q == REQ_PEEK_BACK);
	assign is_rd_kind = is_peek || (kind_q == REQ_DUMP_FWD) || (kind_q == REQ_DUMP_REV);
	assign back_slot  = ring_wrap(sum_t'(front_q) + sum_t'(count_q));
	assign tail_idx   = ring_wrap(sum_t'(front_q) + sum_t'(count_q) - sum_t'(1));

	assign stat.needs_read = is_rd_kind && !empty;
	assign stat.last_elem  = is_peek || ((dump_i_q + cnt_t'(1)) == count_q);
	assign stat.slot_free  = !out_valid_q || rsp.ready;

	// Push and pop. A peek or dump only gets here on an empty deque.
	always_comb begin
		front_nxt   = front_q;
		count_nxt   = count_q;
		exec_status = ST_OK;
		wr_ok       = 1'b0;
		waddr       = ring_dec(front_q);
		unique case (kind_q)
			REQ_PUSH_FRONT: begin
				if (full) begin
					exec_status = ST_FULL;
				end else begin
					wr_ok     = 1'b1;
					front_nxt = ring_dec(front_q);
					count_nxt = count_q + cnt_t'(1);
				end
			end
			REQ_PUSH_BACK: begin
				waddr = back_slot;
				if (full) begin
					exec_status = ST_FULL;
				end else begin
					wr_ok     = 1'b1;
					count_nxt = count_q + cnt_t'(1);
				end
			end
			REQ_POP_FRONT: begin
				if (empty) begin
					exec_status = ST_EMPTY;
				end else begin
					front_nxt = ring_inc(front_q);
					count_nxt = count_q - cnt_t'(1);
				end
			end
			REQ_POP_BACK: begin
				if (empty) begin
					exec_status = ST_EMPTY;
				end else begin
					count_nxt = count_q - cnt_t'(1);
				end
			end
			default: begin
				exec_status = ST_EMPTY;
			end
		endcase
	end

	// A dump walks the ring one entry per read, toward the back or the front.
	assign ram_re = cmd.rd_first || cmd.rd_next;
	always_comb begin
		if (cmd.rd_first) begin
			raddr = from_back ? tail_idx : front_q;
		end else begin
			raddr = from_back ? ring_dec(addr_q) : ring_inc(addr_q);
		end
	end

	deq_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (cmd.exec && wr_ok),
		.waddr (waddr),
		.wdata (value_q),
		.re    (ram_re),
		.raddr (raddr),
		.rdata (rd_data)
	);

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			kind_q  <= req_type;
			value_q <= item_value;
		end
		if (ram_re) begin
			addr_q <= raddr;
		end
		if (cmd.exec) begin
			out_value_q <= '0;
			status_q    <= exec_status;
			last_q      <= 1'b1;
		end else if (cmd.load_rd) begin
			out_value_q <= rd_data;
			status_q    <= ST_OK;
			last_q      <= stat.last_elem;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q     <= '0;
			count_q     <= '0;
			dump_i_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.exec) begin
				front_q <= front_nxt;
				count_q <= count_nxt;
			end
			if (cmd.rd_first) begin
				dump_i_q <= '0;
			end else if (cmd.rd_next) begin
				dump_i_q <= dump_i_q + cnt_t'(1);
			end
			if (cmd.exec || cmd.load_rd) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.out_value   = out_value_q;
	assign rsp.status      = status_q;
	assign rsp.last_of_run = last_q;
endmodule

// File: hw/rtl/double_ended_queue.sv
// ----------------------------------------------------------------------------
// Double-ended queue
// Bounded deque of signed 32-bit values in a ring store, with push, pop and
// peek at either end and dumps in either direction.
// ----------------------------------------------------------------------------
// The block handles one request at a time. A push, a pop, or any request
// refused as full or empty loads its result into the result register in the
// execute state once that register is free, and the controller then returns
// to idle. A peek starts a registered read of the value store in the execute
// state and loads the read data as its result in the read state. A dump of N
// values starts the same way and then delivers one result per cycle while
// the result side keeps taking them; a stall on the result side holds it.
// The single read port of the store sets that pace. The next request is
// taken as soon as the controller is back in its idle state, even while the
// last result still waits in the result register. There is no clearing pass
// after reset: the store is only ever read at entries that hold live values.
module double_ended_queue (
	input  logic      clk,
	input  logic      arst_n,
	deq_req_if.sink   req,
	deq_rsp_if.source rsp
);
	import deq_pkg::*;

	deq_cmd_t  cmd;
	deq_stat_t stat;
	logic      req_ready;

	// The controller owns the request handshake; it only says ready while idle.
	deq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	assign req.ready = req_ready;

	// The datapath holds the ring pointers, the store and the result register,
	// and drives the result channel directly.
	deq_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_type   (req.req_type),
		.item_value (req.item_value),
		.cmd        (cmd),
		.stat       (stat),
		.rsp        (rsp)
	);
endmodule

// File: hw/rtl/deq_checker.sv
// ----------------------------------------------------------------------------
// Deque port checker
// Watches the request and result channels of the deque top level.
// ----------------------------------------------------------------------------
module deq_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              req_valid,
	input logic                              req_ready,
	input logic                              rsp_valid,
	input logic                              rsp_ready,
	input logic signed [deq_pkg::VALUE_W-1:0] out_value,
	input logic [deq_pkg::STATUS_W-1:0]       status,
	input logic                              last_of_run
);
	import deq_pkg::*;

	logic       req_fire;
	logic       run_end;
	logic [1:0] open_q;

	assign req_fire = req_valid && req_ready;
	assign run_end  = rsp_valid && rsp_ready && last_of_run;

	// Requests whose final result has not yet been transferred out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= '0;
		end else if (req_fire && !run_end) begin
			open_q <= open_q + 2'd1;
		end else if (run_end && !req_fire) begin
			open_q <= open_q - 2'd1;
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_value) && $stable(status)
			&& $stable(last_of_run))
		else $error("result changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |=> !req_ready)
		else $error("request taken while the previous one is still at work");

	a_refusal_form: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != ST_OK |-> out_value == '0 && last_of_run)
		else $error("refused request gave a value or a continued run");

	a_no_stray_result: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_ready |-> open_q != 2'd0)
		else $error("result transfer with no open request");

	a_bounded_backlog: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |-> open_q != 2'd2)
		else $error("more than two requests open");
endmodule

bind double_ended_queue deq_checker u_deq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.out_value   (rsp.out_value),
	.status      (rsp.status),
	.last_of_run (rsp.last_of_run)
);

// File: bench/double_ended_queue_test.sv
// ----------------------------------------------------------------------------
// Double-ended queue testbench
// Drives push, pop, peek and dump requests into the deque through its request
// channel and checks every result transfer against a shadow deque kept here.
// ----------------------------------------------------------------------------
module double_ended_queue_test;
	import deq_pkg::*;

	// The longest quiet stretch in a correct run is the receiver's long
	// hold-off; the limit sits well beyond it.
	localparam int WATCHDOG_LIMIT = 2000;
	// The tail spans more than a full dump takes without stalls, so it is enough
	// to catch any stray result that shows up after the last expected one.
	localparam int TAIL_CYCLES    = DEPTH + 40;
	localparam int RANDOM_ITEMS   = 370;
	localparam int HOLD_CYCLES    = 150;

	typedef struct {
		logic [REQ_W-1:0]          kind;
		logic signed [VALUE_W-1:0] value;
		bit                        wait_idle;  // offer only once all results are in
	} deque_request_t;

	typedef struct {
		logic signed [VALUE_W-1:0] value;
		logic [STATUS_W-1:0]       status;
		logic                      last;
	} deque_result_t;

	typedef enum {SEG_FILL, SEG_DRAIN, SEG_MIX, SEG_NOISE} segment_t;

	logic clk;
	logic arst_n;

	deq_req_if req_ch ();
	deq_rsp_if rsp_ch ();

	double_ended_queue i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	deque_request_t pending_requests[$];
	deque_result_t  due_results[$];
	deque_request_t next_request;
	int             error_count = 0;

	// Shadow copy of the deque contents, updated at every request transfer.
	logic signed [VALUE_W-1:0] shadow_store [DEPTH];
	idx_t                      shadow_front = '0;
	cnt_t                      shadow_count = '0;

	// Fill level as seen by the stimulus generator, used only to steer it.
	int gen_level = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Shadow deque
	// ------------------------------------------------------------------------

	function automatic int ring_slot(int offset);
		return (int'(shadow_front) + offset) % DEPTH;
	endfunction

	function automatic void expect_result(logic signed [VALUE_W-1:0] value,
		logic [STATUS_W-1:0] status, logic last);
		deque_result_t r;
		r.value  = value;
		r.status = status;
		r.last   = last;
		due_results.push_back(r);
	endfunction

	// Applies one accepted request to the shadow deque and queues the results
	// the block owes for it.
	function automatic void predict_deque_response(logic [REQ_W-1:0] kind,
		logic signed [VALUE_W-1:0] value);
		int  n;
		int  offset;
		bit  is_empty;
		bit  is_full;
		is_empty = (shadow_count == 0);
		is_full  = (shadow_count >= DEPTH);
		n        = int'(shadow_count);
		case (kind)
			REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
				if (is_full) begin
					// A refused push leaves the contents alone.
					expect_result('0, ST_FULL, 1'b1);
				end else begin
					if (kind == REQ_PUSH_FRONT) begin
						shadow_front = idx_t'(ring_slot(DEPTH - 1));
						shadow_store[shadow_front] = value;
					end else begin
						shadow_store[ring_slot(n)] = value;
					end
					shadow_count = shadow_count + 1'b1;
					expect_result('0, ST_OK, 1'b1);
				end
			end
			REQ_POP_FRONT, REQ_POP_BACK: begin
				if (is_empty) begin
					expect_result('0, ST_EMPTY, 1'b1);
				end else begin
					// Popping the last element from either end leaves it empty.
					if (kind == REQ_POP_FRONT)
						shadow_front = idx_t'(ring_slot(1));
					shadow_count = shadow_count - 1'b1;
					expect_result('0, ST_OK, 1'b1);
				end
			end
			REQ_PEEK_FRONT, REQ_PEEK_BACK: begin
				if (is_empty) begin
					expect_result('0, ST_EMPTY, 1'b1);
				end else begin
					offset = (kind == REQ_PEEK_FRONT) ? 0 : n - 1;
					expect_result(shadow_store[ring_slot(offset)], ST_OK, 1'b1);
				end
			end
			default: begin
				// Dumps: one result per stored value, or a single empty one.
				if (is_empty) begin
					expect_result('0, ST_EMPTY, 1'b1);
				end else begin
					for (int i = 0; i < n; i++) begin
						offset = (kind == REQ_DUMP_FWD) ? i : n - 1 - i;
						expect_result(shadow_store[ring_slot(offset)], ST_OK, i == n - 1);
					end
				end
			end
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus generation
	// ------------------------------------------------------------------------

	function automatic void add_request(logic [REQ_W-1:0] kind,
		logic signed [VALUE_W-1:0] value, bit wait_idle = 1'b0);
		deque_request_t r;
		r.kind      = kind;
		r.value     = value;
		r.wait_idle = wait_idle;
		pending_requests.push_back(r);
		if ((kind == REQ_PUSH_FRONT || kind == REQ_PUSH_BACK) && gen_level < DEPTH)
			gen_level++;
		else if ((kind == REQ_POP_FRONT || kind == REQ_POP_BACK) && gen_level > 0)
			gen_level--;
	endfunction

	// Random payload with the extremes showing up often.
	function automatic logic signed [VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0:       return 32'sh8000_0000;
			1:       return 32'sh7FFF_FFFF;
			2:       return '0;
			3:       return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [REQ_W-1:0] pick_end(logic [REQ_W-1:0] front_kind,
		logic [REQ_W-1:0] back_kind);
		return $urandom_range(0, 1) ? front_kind : back_kind;
	endfunction

	function automatic logic [REQ_W-1:0] pick_dump();
		return pick_end(REQ_DUMP_FWD, REQ_DUMP_REV);
	endfunction

	// Mixed traffic leans toward pushes so the deque spends time at all levels.
	function automatic logic [REQ_W-1:0] pick_mixed_kind();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 40)
			return pick_end(REQ_PUSH_FRONT, REQ_PUSH_BACK);
		else if (roll < 65)
			return pick_end(REQ_POP_FRONT, REQ_POP_BACK);
		else if (roll < 88)
			return pick_end(REQ_PEEK_FRONT, REQ_PEEK_BACK);
		return pick_dump();
	endfunction

	initial begin
		int       issued;
		int       fills;
		int       seg_len;
		bit       pause;
		segment_t seg;

		// Every input is known from time zero, while reset is held low.
		arst_n            = 1'b0;
		req_ch.valid      = 1'b0;
		req_ch.req_type   = REQ_PUSH_FRONT;
		req_ch.item_value = '0;
		rsp_ch.ready      = 1'b0;

		// Directed part. Every peek, pop and dump kind on an empty deque first.
		add_request(REQ_PEEK_FRONT, pick_value());
		add_request(REQ_PEEK_BACK, pick_value());
		add_request(REQ_POP_FRONT, pick_value());
		add_request(REQ_POP_BACK, pick_value());
		add_request(REQ_DUMP_FWD, pick_value());
		add_request(REQ_DUMP_REV, pick_value());
		// A single element popped from the back must leave the deque empty.
		add_request(REQ_PUSH_BACK, 32'sh7FFF_FFFF);
		add_request(REQ_PEEK_BACK, '0);
		add_request(REQ_POP_BACK, '0);
		add_request(REQ_PEEK_FRONT, '0);
		add_request(REQ_DUMP_FWD, '0);
		// Extreme values at both ends, seen through peeks and both dumps.
		add_request(REQ_PUSH_FRONT, 32'sh8000_0000);
		add_request(REQ_PUSH_BACK, '0);
		add_request(REQ_PUSH_FRONT, -32'sd1);
		add_request(REQ_PUSH_BACK, 32'sh5555_5555);
		add_request(REQ_PEEK_FRONT, '0);
		add_request(REQ_PEEK_BACK, '0);
		add_request(REQ_DUMP_FWD, '0);
		add_request(REQ_DUMP_REV, '0);
		// Drain from both ends; the final pop empties it from the front.
		add_request(REQ_POP_FRONT, '0);
		add_request(REQ_POP_BACK, '0);
		add_request(REQ_POP_FRONT, '0);
		add_request(REQ_POP_FRONT, '0);
		add_request(REQ_PEEK_BACK, '0);

		// Random part, built from segments. The first one always fills the
		// deque to the brim, pushes against the full deque and dumps it all,
		// after a pause in which every outstanding result is collected.
		issued = 0;
		fills  = 0;
		while (issued < RANDOM_ITEMS) begin
			if (issued == 0) begin
				seg = SEG_FILL;
			end else begin
				case ($urandom_range(0, 9))
					0:          seg = (fills < 2) ? SEG_FILL : SEG_MIX;
					1, 2:       seg = SEG_DRAIN;
					9:          seg = SEG_NOISE;
					default:    seg = SEG_MIX;
				endcase
			end
			pause = (issued == 0) || ($urandom_range(0, 5) == 0);
			seg_len = pending_requests.size();
			case (seg)
				SEG_FILL: begin
					fills++;
					add_request(pick_end(REQ_PUSH_FRONT, REQ_PUSH_BACK), pick_value(), pause);
					while (gen_level < DEPTH)
						add_request(pick_end(REQ_PUSH_FRONT, REQ_PUSH_BACK), pick_value());
					add_request(REQ_PUSH_FRONT, pick_value());
					add_request(REQ_PUSH_BACK, pick_value());
					add_request(REQ_PEEK_FRONT, pick_value());
					add_request(REQ_PEEK_BACK, pick_value());
					add_request(pick_dump(), pick_value());
				end
				SEG_DRAIN: begin
					add_request(pick_end(REQ_POP_FRONT, REQ_POP_BACK), pick_value(), pause);
					while (gen_level > 0)
						add_request(pick_end(REQ_POP_FRONT, REQ_POP_BACK), pick_value());
					add_request(pick_end(REQ_POP_FRONT, REQ_POP_BACK), pick_value());
					add_request(pick_end(REQ_PEEK_FRONT, REQ_PEEK_BACK), pick_value());
					add_request(pick_dump(), pick_value());
				end
				SEG_MIX: begin
					add_request(pick_mixed_kind(), pick_value(), pause);
					repeat ($urandom_range(14, 29))
						add_request(pick_mixed_kind(), pick_value());
				end
				default: begin
					// Uniform request kinds, with no regard to the fill level.
					add_request(logic'($urandom_range(0, 7)) ? REQ_W'($urandom_range(0, 7))
						: REQ_W'($urandom_range(0, 7)), $urandom, pause);
					repeat ($urandom_range(4, 9))
						add_request(REQ_W'($urandom_range(0, 7)), $urandom);
				end
			endcase
			issued += pending_requests.size() - seg_len;
		end

		repeat (7) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Wait for the driver to run dry, then for the last owed result, then
		// let more than a full dump's worth of cycles pass to catch anything extra.
		while (pending_requests.size() != 0 || req_ch.valid)
			@(posedge clk);
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Request driver
	// ------------------------------------------------------------------------
	// Items go out in bursts of random length separated by random gaps. An
	// item marked wait_idle is held back until the block has delivered every
	// result it owes; the cycle right after a transfer is skipped as well, so
	// the prediction for that transfer is already in the queue when we look.
	int burst_left;
	int gap_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			burst_left   <= 0;
			gap_left     <= 0;
		end else if (req_ch.valid && !req_ch.ready) begin
			// Stalled: the current item stays on the channel unchanged.
		end else if (gap_left != 0) begin
			req_ch.valid <= 1'b0;
			gap_left     <= gap_left - 1;
		end else if (pending_requests.size() == 0) begin
			req_ch.valid <= 1'b0;
		end else if (pending_requests[0].wait_idle &&
			(req_ch.valid || due_results.size() != 0)) begin
			req_ch.valid <= 1'b0;
		end else begin
			next_request        = pending_requests.pop_front();
			req_ch.valid       <= 1'b1;
			req_ch.req_type    <= next_request.kind;
			req_ch.item_value  <= next_request.value;
			if (burst_left <= 1) begin
				burst_left <= $urandom_range(1, 24);
				gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			end else begin
				burst_left <= burst_left - 1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Result receiver
	// ------------------------------------------------------------------------
	// Ready follows phases of random length, each with its own stall rate,
	// some of them stall free. At two points the receiver holds off for a long
	// stretch while the driver keeps offering, so the block backs up and
	// stalls its request side.
	int results_taken = 0;
	int hold_left     = 0;
	int phase_left    = 0;
	int stall_pct     = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				results_taken++;
				if (results_taken == 120 || results_taken == 600)
					hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				if (phase_left == 0) begin
					phase_left = $urandom_range(10, 60);
					case ($urandom_range(0, 2))
						0:       stall_pct = 0;
						1:       stall_pct = 25;
						default: stall_pct = 60;
					endcase
				end
				phase_left--;
				rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor and scoreboard
	// ------------------------------------------------------------------------
	// Both channels are sampled at the rising edge, before this edge's
	// updates land. A result transfer is checked against the oldest owed
	// result; a request transfer then feeds the shadow deque.
	deque_result_t owed;

	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (due_results.size() == 0) begin
					$error("result transfer with no result owed: value %0d status %0d",
						rsp_ch.out_value, rsp_ch.status);
					error_count++;
				end else begin
					owed = due_results.pop_front();
					if (rsp_ch.out_value !== owed.value) begin
						$error("out_value: expected %0d, got %0d", owed.value, rsp_ch.out_value);
						error_count++;
					end
					if (rsp_ch.status !== owed.status) begin
						$error("status: expected %0d, got %0d", owed.status, rsp_ch.status);
						error_count++;
					end
					if (rsp_ch.last_of_run !== owed.last) begin
						$error("last_of_run: expected %0d, got %0d", owed.last,
							rsp_ch.last_of_run);
						error_count++;
					end
				end
			end
			if (req_ch.valid && req_ch.ready)
				predict_deque_response(req_ch.req_type, req_ch.item_value);
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog
	// ------------------------------------------------------------------------
	// Counts cycles in which neither channel completes a transfer.
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

endmodule
